/* rtl/assert_macros.svh */
// Assertion helpers used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define HSS_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define HSS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* rtl/hss_pkg.sv */
// ----------------------------------------------------------------------------
// hss_pkg
// Grid geometry, datapath widths and control types shared by the stencil
// sweep modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hss_pkg;

	// grid geometry
	localparam int ROWS = 10;
	localparam int COLS = 20;

	// counter widths
	localparam int ROW_W   = $clog2(ROWS);
	localparam int COL_W   = $clog2(COLS);
	localparam int FLUSH_W = $clog2(COLS + 2);

	// line lengths: raw window and swept history
	localparam int RAW_LEN = COLS + 1;
	localparam int UPD_LEN = COLS + 1;

	// datapath
	localparam int DATA_W   = 16;
	localparam int SUM6_W   = 19;  // 2*X + four raw neighbors
	localparam int SUM_W    = 20;  // plus three swept neighbors from the row above
	localparam int PROD_W   = 34;  // scaled sum with rounding
	localparam int KPROD_W  = 29;  // swept left neighbor times the scale
	localparam int SCALE_SH = 16;
	localparam int MUL_K    = 6554;   // 0.1 in Q0.16
	localparam int ROUND_K  = 32768;  // one half in Q0.16

	localparam logic [DATA_W-1:0] DATA_MAX = '1;

	// per-cell control from the sequencer
	typedef struct packed {
		logic shift;      // raw line moves one place
		logic issue;      // a cell enters the datapath
		logic border;     // cell lies on the grid border
		logic cell_last;  // final cell of the grid
		logic run_last;   // last result caused by the current input beat
	} issue_t;

endpackage

`default_nettype wire

/* rtl/hss_line_cell.sv */
// ----------------------------------------------------------------------------
// hss_line_cell
// One sample slot of a shift line: takes its neighbor's sample when the line
// moves and holds it otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_line_cell (
	input  wire logic                         clk,
	input  wire logic                         shift,
	input  wire logic [hss_pkg::DATA_W-1:0]   d,
	output logic      [hss_pkg::DATA_W-1:0]   q
);

	logic [hss_pkg::DATA_W-1:0] data_q;

	// slot storage
	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d;
		end
	end

	assign q = data_q;

endmodule

`default_nettype wire

/* rtl/hss_seq.sv */
// ----------------------------------------------------------------------------
// hss_seq
// Input and cell position counters, start-of-frame fill and end-of-frame
// flush control for the stencil sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_seq (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       en,
	output logic            in_ready,
	output hss_pkg::issue_t ctl
);

	logic [hss_pkg::ROW_W-1:0]   row_q;
	logic [hss_pkg::COL_W-1:0]   col_q;
	logic [hss_pkg::ROW_W-1:0]   crow_q;
	logic [hss_pkg::COL_W-1:0]   ccol_q;
	logic [hss_pkg::FLUSH_W-1:0] flush_q;

	logic flushing;
	logic accept;
	logic flush_step;
	logic in_last;
	logic past_fill;
	logic cell_last;

	// handshake and cell issue
	always_comb begin
		flushing   = (flush_q != '0);
		in_ready   = en && !flushing;
		accept     = in_valid && in_ready;
		flush_step = flushing && en;
		in_last    = (row_q == hss_pkg::ROW_W'(hss_pkg::ROWS - 1)) &&
		             (col_q == hss_pkg::COL_W'(hss_pkg::COLS - 1));
		// first COLS+1 beats of a frame only fill the window
		past_fill  = (row_q > hss_pkg::ROW_W'(1)) ||
		             ((row_q == hss_pkg::ROW_W'(1)) && (col_q != '0));
		cell_last  = (crow_q == hss_pkg::ROW_W'(hss_pkg::ROWS - 1)) &&
		             (ccol_q == hss_pkg::COL_W'(hss_pkg::COLS - 1));

		ctl.shift     = accept || flush_step;
		ctl.issue     = (accept && past_fill) || flush_step;
		ctl.cell_last = cell_last;
		ctl.border    = (crow_q == '0) || (ccol_q == '0) ||
		                (crow_q == hss_pkg::ROW_W'(hss_pkg::ROWS - 1)) ||
		                (ccol_q == hss_pkg::COL_W'(hss_pkg::COLS - 1));
		ctl.run_last  = cell_last || (accept && !in_last);
	end

	// input position and flush count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			flush_q <= '0;
		end else begin
			if (accept) begin
				if (in_last) begin
					row_q   <= '0;
					col_q   <= '0;
					flush_q <= hss_pkg::FLUSH_W'(hss_pkg::COLS + 1);
				end else if (col_q == hss_pkg::COL_W'(hss_pkg::COLS - 1)) begin
					col_q <= '0;
					row_q <= row_q + hss_pkg::ROW_W'(1);
				end else begin
					col_q <= col_q + hss_pkg::COL_W'(1);
				end
			end else if (flush_step) begin
				flush_q <= flush_q - hss_pkg::FLUSH_W'(1);
			end
		end
	end

	// position of the cell entering the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crow_q <= '0;
			ccol_q <= '0;
		end else if (ctl.issue) begin
			if (cell_last) begin
				crow_q <= '0;
				ccol_q <= '0;
			end else if (ccol_q == hss_pkg::COL_W'(hss_pkg::COLS - 1)) begin
				ccol_q <= '0;
				crow_q <= crow_q + hss_pkg::ROW_W'(1);
			end else begin
				ccol_q <= ccol_q + hss_pkg::COL_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/inplace_heat_stencil_sweep.sv */
// ----------------------------------------------------------------------------
// inplace_heat_stencil_sweep
// One in-place 3x3 Gauss-Seidel heat sweep over a raster stream of Q8.8
// temperatures; border cells pass, interior cells take 0.1 of the weighted
// neighborhood sum using the already swept upper row and left neighbor.
// ----------------------------------------------------------------------------
//  channel  signals                              beat
//  in       in_valid in_ready temp_in            one grid sample, raster order
//  out      out_valid out_ready temp_out         one swept sample, raster order
//           frame_end run_last
//
//  Input beats are taken one per cycle while in_ready is high; a result passes
//  the stage 1, stage 2 and output registers after the beat that completes its
//  window, i.e. COLS+1 beats behind its own sample. After the final beat of a
//  frame a flush issues the last COLS+1 cells with in_ready low.
//  The loop through the swept left neighbor closes in the last stage.
//  The whole pipeline holds while a result waits on out_ready.
//  Reset clears counters and valid flags; line contents need none.
// ----------------------------------------------------------------------------
`default_nettype none

module inplace_heat_stencil_sweep (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [hss_pkg::DATA_W-1:0]   temp_in,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [hss_pkg::DATA_W-1:0]   temp_out,
	output logic                              frame_end,
	output logic                              run_last
);

	hss_pkg::issue_t ctl;
	logic            en;

	logic [hss_pkg::DATA_W-1:0] raw_q [hss_pkg::RAW_LEN];
	logic [hss_pkg::DATA_W-1:0] upd_q [hss_pkg::UPD_LEN];

	// stage 1: raw part of the sum
	logic                        valid_s1;
	logic [hss_pkg::SUM6_W-1:0]  sum_s1;
	logic [hss_pkg::DATA_W-1:0]  raw_s1;
	logic                        border_s1;
	logic                        last_s1;
	logic                        runl_s1;

	// stage 2: scaled sum without the left neighbor
	logic                        valid_s2;
	logic [hss_pkg::PROD_W-1:0]  prod_s2;
	logic [hss_pkg::DATA_W-1:0]  raw_s2;
	logic                        border_s2;
	logic                        last_s2;
	logic                        runl_s2;

	// output register
	logic                        out_valid_q;
	logic [hss_pkg::DATA_W-1:0]  temp_out_q;
	logic                        frame_end_q;
	logic                        run_last_q;

	logic [hss_pkg::SUM6_W-1:0]  sum_a;
	logic [hss_pkg::DATA_W-1:0]  u_ul;
	logic [hss_pkg::DATA_W-1:0]  u_up;
	logic [hss_pkg::DATA_W-1:0]  u_ur;
	logic [hss_pkg::SUM_W-1:0]   sum_b;
	logic [hss_pkg::PROD_W-1:0]  prod_b;
	logic [hss_pkg::KPROD_W-1:0] left_k;
	logic [hss_pkg::PROD_W-1:0]  tot_c;
	logic [hss_pkg::PROD_W-hss_pkg::SCALE_SH-1:0] scaled_c;
	logic [hss_pkg::DATA_W-1:0]  v_c;

	// pipeline moves whenever the output register can take a beat
	assign en = !out_valid_q || out_ready;

	hss_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.en       (en),
		.in_ready (in_ready),
		.ctl      (ctl)
	);

	// raw window: raw_q[0] newest, raw_q[RAW_LEN-1] is the issuing cell
	for (genvar gi = 0; gi < hss_pkg::RAW_LEN; gi++) begin : g_raw
		if (gi == 0) begin : g_head
			hss_line_cell u_cell (
				.clk   (clk),
				.shift (ctl.shift),
				.d     (temp_in),
				.q     (raw_q[gi])
			);
		end else begin : g_tail
			hss_line_cell u_cell (
				.clk   (clk),
				.shift (ctl.shift),
				.d     (raw_q[gi-1]),
				.q     (raw_q[gi])
			);
		end
	end

	// swept history: upd_q[0] is the last result produced
	for (genvar gi = 0; gi < hss_pkg::UPD_LEN; gi++) begin : g_upd
		if (gi == 0) begin : g_head
			hss_line_cell u_cell (
				.clk   (clk),
				.shift (valid_s2 && en),
				.d     (v_c),
				.q     (upd_q[gi])
			);
		end else begin : g_tail
			hss_line_cell u_cell (
				.clk   (clk),
				.shift (valid_s2 && en),
				.d     (upd_q[gi-1]),
				.q     (upd_q[gi])
			);
		end
	end

	// stage A: twice the center plus right, lower-left, lower, lower-right
	always_comb begin
		sum_a = (hss_pkg::SUM6_W'(raw_q[hss_pkg::COLS]) << 1)
		      + hss_pkg::SUM6_W'(raw_q[hss_pkg::COLS-1])
		      + hss_pkg::SUM6_W'(raw_q[1])
		      + hss_pkg::SUM6_W'(raw_q[0])
		      + hss_pkg::SUM6_W'(temp_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= ctl.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (en && ctl.issue) begin
			sum_s1    <= sum_a;
			raw_s1    <= raw_q[hss_pkg::COLS];
			border_s1 <= ctl.border;
			last_s1   <= ctl.cell_last;
			runl_s1   <= ctl.run_last;
		end
	end

	// stage B: upper row taps; the newest swept value is one cell further
	// back when the previous cell still sits in stage 2
	always_comb begin
		u_ul = valid_s2 ? upd_q[hss_pkg::COLS-1] : upd_q[hss_pkg::COLS];
		u_up = valid_s2 ? upd_q[hss_pkg::COLS-2] : upd_q[hss_pkg::COLS-1];
		u_ur = valid_s2 ? upd_q[hss_pkg::COLS-3] : upd_q[hss_pkg::COLS-2];
		sum_b = hss_pkg::SUM_W'(sum_s1)
		      + hss_pkg::SUM_W'(u_ul)
		      + hss_pkg::SUM_W'(u_up)
		      + hss_pkg::SUM_W'(u_ur);
		prod_b = hss_pkg::PROD_W'(sum_b) * hss_pkg::PROD_W'(hss_pkg::MUL_K)
		       + hss_pkg::PROD_W'(hss_pkg::ROUND_K);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			prod_s2   <= prod_b;
			raw_s2    <= raw_s1;
			border_s2 <= border_s1;
			last_s2   <= last_s1;
			runl_s2   <= runl_s1;
		end
	end

	// stage C: add the swept left neighbor, scale down and saturate
	always_comb begin
		left_k   = hss_pkg::KPROD_W'(upd_q[0]) * hss_pkg::KPROD_W'(hss_pkg::MUL_K);
		tot_c    = prod_s2 + hss_pkg::PROD_W'(left_k);
		scaled_c = tot_c[hss_pkg::PROD_W-1:hss_pkg::SCALE_SH];
		if (border_s2) begin
			v_c = raw_s2;
		end else if (scaled_c > (hss_pkg::PROD_W - hss_pkg::SCALE_SH)'(hss_pkg::DATA_MAX)) begin
			v_c = hss_pkg::DATA_MAX;
		end else begin
			v_c = scaled_c[hss_pkg::DATA_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2) begin
			temp_out_q  <= v_c;
			frame_end_q <= last_s2;
			run_last_q  <= runl_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign temp_out  = temp_out_q;
	assign frame_end = frame_end_q;
	assign run_last  = run_last_q;

endmodule

`default_nettype wire

/* rtl/hss_checker.sv */
// ----------------------------------------------------------------------------
// hss_checker
// Port-level checks for the stencil sweep: output hold under stall, input
// gating by the output side, and end-of-frame flag pairing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hss_checker (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic                         in_ready,
	input  wire logic                         out_valid,
	input  wire logic                         out_ready,
	input  wire logic [hss_pkg::DATA_W-1:0]   temp_out,
	input  wire logic                         frame_end,
	input  wire logic                         run_last
);

	// a stalled result beat stays up
	`HSS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "out beat dropped while stalled")

	// a stalled result beat keeps its payload
	`HSS_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(temp_out) && $stable(frame_end) && $stable(run_last), "out payload changed while stalled")

	// input is taken only when the output side can move
	`HSS_ASSERT_NOW(a_in_gate, clk, arst_n, in_ready, !out_valid || out_ready, "in_ready high while output is blocked")

	// the final cell of a grid closes its run
	`HSS_ASSERT_NOW(a_end_run, clk, arst_n, out_valid && frame_end, run_last, "frame_end without run_last")

	// no open-ended frame end shows while an input beat is taken
	`HSS_ASSERT_NOW(a_no_in_with_flush, clk, arst_n, in_valid && in_ready, !(out_valid && frame_end && !run_last), "frame_end beat with run_last low")

endmodule

bind inplace_heat_stencil_sweep hss_checker u_hss_checker (.*);

`default_nettype wire

/* dv/inplace_heat_stencil_sweep_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inplace_heat_stencil_sweep_tb
// Streams raster frames of Q8.8 temperatures through the in-place heat sweep
// and checks every swept sample, frame_end and run_last flag against a local
// Gauss-Seidel predictor. The sender idles in random bursts, the receiver
// stalls on its own pattern and once holds off long enough to back up the
// pipeline into the input.
// ----------------------------------------------------------------------------

module inplace_heat_stencil_sweep_tb;

	localparam int ROWS      = hss_pkg::ROWS;
	localparam int COLS      = hss_pkg::COLS;
	localparam int DATA_W    = hss_pkg::DATA_W;
	localparam int CELLS     = ROWS * COLS;
	localparam int RAW_DEPTH = 2 * COLS + 1;
	localparam int N_BEATS   = 2 * CELLS + 10;
	localparam int N_FIXED   = COLS + 5;
	localparam int HOLD_AT   = 300;
	localparam int HOLD_LEN  = 300;
	localparam int LIMIT     = 200000;

	typedef logic [DATA_W-1:0] temp_t;

	typedef struct packed {
		temp_t temp;
		logic  frame_end;
		logic  run_last;
	} swept_cell_t;

	typedef enum int {ROW_NOISE, ROW_HOT, ROW_NEAR_HOT, ROW_COLD, ROW_LOW, ROW_RAMP} row_mode_t;
	typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE} rx_mode_t;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  in_valid  = 1'b0;
	temp_t temp_in   = '0;
	logic  out_ready = 1'b0;
	logic  in_ready;
	logic  out_valid;
	temp_t temp_out;
	logic  frame_end;
	logic  run_last;

	inplace_heat_stencil_sweep i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.temp_in   (temp_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.temp_out  (temp_out),
		.frame_end (frame_end),
		.run_last  (run_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// samples waiting to be sent, swept cells waiting to come back
	temp_t       grid_samples[$];
	swept_cell_t swept_due[$];
	int          mismatch_count = 0;

	// predictor state: swept row above, recent raw samples, left neighbor
	temp_t       upper_swept[COLS];
	temp_t       raw_window[RAW_DEPTH];
	temp_t       left_swept;
	int unsigned cell_row;
	int unsigned cell_col;

	// swept value of cell lin; updates the swept row and left neighbor
	function automatic temp_t sweep_cell_value(int unsigned lin);
		int unsigned r;
		int unsigned c;
		logic [19:0] nbr_sum;
		logic [35:0] scaled;
		temp_t       v;
		r = lin / COLS;
		c = lin % COLS;
		if (r == 0 || r == ROWS - 1 || c == 0 || c == COLS - 1) begin
			v = raw_window[lin % RAW_DEPTH];
		end else begin
			nbr_sum = 20'(upper_swept[c - 1]) + 20'(upper_swept[c]) + 20'(upper_swept[c + 1])
				+ 20'(left_swept) + 20'(raw_window[lin % RAW_DEPTH]) * 20'd2
				+ 20'(raw_window[(lin + 1) % RAW_DEPTH])
				+ 20'(raw_window[(lin + COLS - 1) % RAW_DEPTH])
				+ 20'(raw_window[(lin + COLS) % RAW_DEPTH])
				+ 20'(raw_window[(lin + COLS + 1) % RAW_DEPTH]);
			scaled = (36'(nbr_sum) * 36'd6554 + 36'd32768) >> 16;
			v = (scaled > 36'd65535) ? 16'hFFFF : scaled[15:0];
		end
		if (c >= 1)
			upper_swept[c - 1] = left_swept;
		if (c == COLS - 1)
			upper_swept[c] = v;
		left_swept = v;
		return v;
	endfunction

	// one accepted sample: store it and queue the swept cells it releases
	function automatic void queue_swept_cells(temp_t sample);
		int unsigned lin;
		int unsigned first;
		int unsigned stop;
		logic        last;
		swept_cell_t due;
		lin  = cell_row * COLS + cell_col;
		last = (lin == CELLS - 1);
		raw_window[lin % RAW_DEPTH] = sample;
		if (lin >= COLS + 1) begin
			first = lin - (COLS + 1);
			stop  = last ? CELLS - 1 : first;
			for (int unsigned k = first; k <= stop; k++) begin
				due.temp      = sweep_cell_value(k);
				due.frame_end = (k == CELLS - 1);
				due.run_last  = (k == stop);
				swept_due.push_back(due);
			end
		end
		if (last) begin
			cell_row   = 0;
			cell_col   = 0;
			left_swept = '0;
		end else begin
			cell_col++;
			if (cell_col >= COLS) begin
				cell_col = 0;
				cell_row++;
			end
		end
	endfunction

	function automatic temp_t row_sample(row_mode_t mode, int col);
		case (mode)
			ROW_HOT:      return 16'hFFFF;
			ROW_NEAR_HOT: return temp_t'(65535 - $urandom_range(0, 255));
			ROW_COLD:     return '0;
			ROW_LOW:      return temp_t'($urandom_range(0, 255));
			ROW_RAMP:     return temp_t'(col * 3000 + $urandom_range(0, 999));
			default:      return temp_t'($urandom_range(0, 65535));
		endcase
	endfunction

	// driver: bursts of beats with random gaps
	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			temp_in  <= '0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0 || grid_samples.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				temp_in  <= grid_samples.pop_front();
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 30);
					gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
						: $urandom_range(0, 3);
				end
			end
		end
	end

	// receiver: stall pattern drawn at random from open, half and sparse modes, plus one long hold-off
	int       rx_cycle  = 0;
	int       hold_left = 0;
	rx_mode_t rx_mode   = RX_OPEN;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			rx_cycle++;
			if (rx_cycle == HOLD_AT)
				hold_left = HOLD_LEN;
			if (rx_cycle % 48 == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 2));
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:   out_ready <= 1'b1;
				endcase
			end
		end
	end

	// monitor: predict on input beats, check output beats
	always @(posedge clk or negedge arst_n) begin
		swept_cell_t want;
		if (!arst_n) begin
			left_swept = '0;
			cell_row   = 0;
			cell_col   = 0;
		end else begin
			if (in_valid && in_ready)
				queue_swept_cells(temp_in);
			if (out_valid && out_ready) begin
				if (swept_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected beat: temp_out=%h frame_end=%b run_last=%b",
							temp_out, frame_end, run_last);
				end else begin
					want = swept_due.pop_front();
					if (temp_out !== want.temp || frame_end !== want.frame_end
						|| run_last !== want.run_last) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: temp_out %h/%h frame_end %b/%b run_last %b/%b (exp/act)",
								want.temp, temp_out, want.frame_end, frame_end,
								want.run_last, run_last);
					end
				end
			end
		end
	end

	// watchdog
	int cycle_count = 0;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		row_mode_t mode;
		mode = ROW_NOISE;

		// top border at full scale, then zero, single-bit and alternating-bit patterns
		for (int j = 0; j < COLS; j++)
			grid_samples.push_back(16'hFFFF);
		grid_samples.push_back(16'h0000);
		grid_samples.push_back(16'h0001);
		grid_samples.push_back(16'h8000);
		grid_samples.push_back(16'h5555);
		grid_samples.push_back(16'hAAAA);

		// rest of rows 1 and 2 of the first frame hot so interior cells saturate, later rows in random modes
		for (int idx = N_FIXED; idx < N_BEATS; idx++) begin
			if (idx % COLS == 0 || idx == N_FIXED) begin
				if (idx < 3 * COLS)
					mode = ROW_HOT;
				else
					mode = row_mode_t'($urandom_range(0, 9) > 5 ? $urandom_range(1, 5) : 0);
			end
			grid_samples.push_back(row_sample(mode, idx % COLS));
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (grid_samples.size() != 0 || in_valid)
			@(negedge clk);
		while (swept_due.size() != 0)
			@(negedge clk);
		repeat (3 * COLS) @(posedge clk);

		if (mismatch_count == 0 && swept_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
